FILE: rtl/pidta_pkg.sv
// ----------------------------------------------------------------------------
// pidta_pkg: shared types, constants and helpers for the PID controller
// Widths, register indexes, flag codes and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package pidta_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned INTEG_W   = 48;
  localparam int unsigned DT_W      = 24;

  // Divider: magnitude of a (DATA_W+1)-bit value scaled by 2^FRAC_BITS.
  localparam int unsigned DVD_W      = DATA_W + 1 + FRAC_BITS;
  localparam int unsigned DSR_W      = DATA_W;
  localparam int unsigned DIV_STEPS  = DVD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned SAT_W      = DVD_W + 1;

  // Shared multiplier: (DATA_W+1) x DATA_W unsigned.
  localparam int unsigned MA_W   = DATA_W + 1;
  localparam int unsigned MB_W   = DATA_W;
  localparam int unsigned PROD_W = MA_W + MB_W;

  // Product terms are limited to 2^(2*DATA_W-2) before scaling.
  localparam int unsigned TERM_W = 2 * DATA_W - FRAC_BITS;
  localparam logic [PROD_W-1:0] TERM_LIMIT = PROD_W'(1) << (2 * DATA_W - 2);
  localparam int unsigned SUM_W  = TERM_W + 2;

  // Integral bounds used when the integral gain is zero: 1e6 in Q.FRAC_BITS.
  localparam logic signed [INTEG_W-1:0] IBOUND_DEF =
    INTEG_W'(64'd1000000 << FRAC_BITS);

  localparam int unsigned IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_OUTPUT_MAX = 3'd3,
    REG_OUTPUT_MIN = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    LIM_NONE = 2'd0,
    LIM_MAX  = 2'd1,
    LIM_MIN  = 2'd2
  } limit_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] abs_data(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

  function automatic logic [DATA_W:0] abs_wide(input logic [DATA_W:0] v);
    return v[DATA_W] ? ((DATA_W + 1)'(0) - v) : v;
  endfunction

  function automatic logic [INTEG_W-1:0] abs_integ(input logic [INTEG_W-1:0] v);
    return v[INTEG_W-1] ? (INTEG_W'(0) - v) : v;
  endfunction

  // Gives a magnitude its sign and saturates it to a signed w-bit range.
  function automatic logic signed [SAT_W-1:0] sat_mag(input logic [DVD_W-1:0] mag,
                                                      input logic neg,
                                                      input int unsigned w);
    logic signed [SAT_W-1:0] v;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    v  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    hi = $signed((SAT_W'(1) << (w - 1)) - SAT_W'(1));
    lo = -hi - SAT_W'(1);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Limits a product magnitude, drops the fraction bits and applies the sign.
  function automatic logic signed [TERM_W-1:0] scale_term(input logic [PROD_W-1:0] mag,
                                                          input logic neg);
    logic [PROD_W-1:0] m;
    logic [TERM_W-1:0] s;
    m = (mag > TERM_LIMIT) ? TERM_LIMIT : mag;
    s = TERM_W'(m >> FRAC_BITS);
    return neg ? -$signed(s) : $signed(s);
  endfunction

endpackage

FILE: rtl/pidta_div.sv
// ----------------------------------------------------------------------------
// pidta_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by all quotients.
// ----------------------------------------------------------------------------
module pidta_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidta_pkg::div_req_t req_i,
  output pidta_pkg::div_rsp_t rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [pidta_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [pidta_pkg::DVD_W-1:0]      dq_q;
  logic [pidta_pkg::DSR_W-1:0]      rem_q;
  logic [pidta_pkg::DSR_W-1:0]      dsr_q;

  logic [pidta_pkg::DSR_W:0] trial;
  logic [pidta_pkg::DSR_W:0] trial_sub;
  logic                      take;

  // The dividend shifts out of the top of dq_q while quotient bits enter below.
  assign trial     = {rem_q, dq_q[pidta_pkg::DVD_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign take      = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + pidta_pkg::DIV_CNT_W'(1);
      if (cnt_q == pidta_pkg::DIV_CNT_W'(pidta_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? trial_sub[pidta_pkg::DSR_W-1:0] : trial[pidta_pkg::DSR_W-1:0];
      dq_q  <= {dq_q[pidta_pkg::DVD_W-2:0], take};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

FILE: rtl/pid_trapezoid_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_trapezoid_antiwindup: PID controller with trapezoid integral and clamp
// Sequenced datapath around one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage. Each request on the slave stream carries an error sample and the
// time elapsed since the previous sample. The block answers every request
// with exactly one request on the master stream: the limited drive value in
// tdata and a limit flag in tuser (none, clamped to maximum, to minimum).
// Gains and output limits are to be written through the plain write port while the
// block is idle; the block does not enforce this. They take effect from the next sample on.
//
// Sequencing. One request is worked on at a time; tready is low
// until its result is in the output register. The derivative quotient runs
// through the shared one-bit-per-cycle divider (49 steps), followed by five
// multiply steps and an output step. The integral bounds are kept from one
// sample to the next; after a write to the integral gain or to either output
// limit they are divided anew for the next request, or set to the defaults
// when the integral gain is zero. A zero step time skips the derivative
// division.
//
// Reset clears the gains to zero, the limits to +1.0 and -1.0, the previous
// error and the integral to zero. The output register holds its request
// while the receiver stalls; the block takes the next input meanwhile and
// waits only when the next result is ready and the register is still full.
// ----------------------------------------------------------------------------
module pid_trapezoid_antiwindup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [pidta_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [pidta_pkg::DATA_W-1:0]  cfg_data_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [55:0]                   s_axis_tdata,   // [31:0] error_in, [55:32] step_time
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] control_out
  output logic [1:0]                    m_axis_tuser    // [1:0] limit_hit
);

  localparam int unsigned DW = pidta_pkg::DATA_W;
  localparam int unsigned IW = pidta_pkg::INTEG_W;
  localparam int unsigned FB = pidta_pkg::FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_BMAX  = 10'b00_0000_0010,
    S_BMIN  = 10'b00_0000_0100,
    S_DDIV  = 10'b00_0000_1000,
    S_MSTEP = 10'b00_0001_0000,
    S_ACC   = 10'b00_0010_0000,
    S_CLMP  = 10'b00_0100_0000,
    S_MI0   = 10'b00_1000_0000,
    S_MI1   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q;

  // Configuration registers
  logic signed [DW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic signed [DW-1:0] output_max_q, output_min_q;

  // Persistent state
  logic signed [DW-1:0] last_err_q;
  logic signed [IW-1:0] isum_q;
  logic signed [IW-1:0] imax_q, imin_q;
  logic                 bnd_ok_q;

  // Per-sample working registers
  logic signed [DW-1:0]                  err_q;
  logic [pidta_pkg::DT_W-1:0]            dt_q;
  logic signed [DW:0]                    diff_q;
  logic signed [DW:0]                    esum_q;
  logic signed [DW-1:0]                  deriv_q;
  logic signed [IW:0]                    sum_q;
  logic [pidta_pkg::PROD_W-1:0]          prod_q;
  logic [pidta_pkg::PROD_W-2:0]          plo_q;
  logic signed [pidta_pkg::TERM_W-1:0]   term_p_q;
  logic signed [pidta_pkg::TERM_W:0]     acc_q;
  logic                                  started_q;

  // Output register
  logic                 m_valid_q;
  logic [DW-1:0]        m_data_q;
  pidta_pkg::limit_e    m_lim_q;

  // Input unpacking
  logic signed [DW-1:0]       err_in;
  logic [pidta_pkg::DT_W-1:0] dt_in;
  logic                       in_acc;

  assign err_in = s_axis_tdata[31:0];
  assign dt_in  = s_axis_tdata[55:32];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Configuration writes. Writing the integral gain or a limit invalidates
  // the cached integral bounds. Unknown indexes are ignored.
  // --------------------------------------------------------------------------
  logic bnd_kill;

  always_comb begin
    bnd_kill = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pidta_pkg::REG_GAIN_INTEG: bnd_kill = 1'b1;
        pidta_pkg::REG_OUTPUT_MAX: bnd_kill = 1'b1;
        pidta_pkg::REG_OUTPUT_MIN: bnd_kill = 1'b1;
        default:                   bnd_kill = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      output_max_q <= DW'(1) << FB;
      output_min_q <= -(DW'(1) << FB);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidta_pkg::REG_GAIN_PROP:  gain_prop_q  <= cfg_data_i;
        pidta_pkg::REG_GAIN_INTEG: gain_integ_q <= cfg_data_i;
        pidta_pkg::REG_GAIN_DERIV: gain_deriv_q <= cfg_data_i;
        pidta_pkg::REG_OUTPUT_MAX: output_max_q <= cfg_data_i;
        pidta_pkg::REG_OUTPUT_MIN: output_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider. Operands are magnitudes; the sign is applied afterwards.
  // --------------------------------------------------------------------------
  pidta_pkg::div_req_t div_req;
  pidta_pkg::div_rsp_t div_rsp;
  logic                gi_zero;
  logic                dt_zero;

  assign gi_zero = (gain_integ_q == '0);
  assign dt_zero = (dt_q == '0);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_BMAX: begin
        div_req.start    = !started_q && !gi_zero;
        div_req.dividend = {1'b0, pidta_pkg::abs_data(output_max_q), FB'(0)};
        div_req.divisor  = pidta_pkg::abs_data(gain_integ_q);
      end
      S_BMIN: begin
        div_req.start    = !started_q;
        div_req.dividend = {1'b0, pidta_pkg::abs_data(output_min_q), FB'(0)};
        div_req.divisor  = pidta_pkg::abs_data(gain_integ_q);
      end
      S_DDIV: begin
        div_req.start    = !started_q && !dt_zero;
        div_req.dividend = {pidta_pkg::abs_wide(diff_q), FB'(0)};
        div_req.divisor  = pidta_pkg::DSR_W'(dt_q);
      end
      default: ;
    endcase
  end

  pidta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Signed results of the current quotient.
  logic signed [pidta_pkg::SAT_W-1:0] q_max, q_min, q_der;
  logic signed [IW-1:0]               bmax_new, bmin_new;

  assign q_max = pidta_pkg::sat_mag(div_rsp.quotient,
                                    output_max_q[DW-1] ^ gain_integ_q[DW-1], IW);
  assign q_min = pidta_pkg::sat_mag(div_rsp.quotient,
                                    output_min_q[DW-1] ^ gain_integ_q[DW-1], IW);
  assign q_der = pidta_pkg::sat_mag(div_rsp.quotient, diff_q[DW], DW);
  assign bmax_new = q_max[IW-1:0];
  assign bmin_new = q_min[IW-1:0];

  // --------------------------------------------------------------------------
  // Shared multiplier. Each multiply step registers its product in prod_q,
  // which the following step consumes.
  // --------------------------------------------------------------------------
  logic [pidta_pkg::MA_W-1:0] mul_a;
  logic [pidta_pkg::MB_W-1:0] mul_b;
  logic [IW-1:0]              isum_mag;

  assign isum_mag = pidta_pkg::abs_integ(isum_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MSTEP: begin
        mul_a = pidta_pkg::abs_wide(esum_q);
        mul_b = pidta_pkg::MB_W'(dt_q);
      end
      S_ACC: begin
        mul_a = {1'b0, pidta_pkg::abs_data(gain_prop_q)};
        mul_b = pidta_pkg::abs_data(err_q);
      end
      S_CLMP: begin
        mul_a = {1'b0, pidta_pkg::abs_data(gain_deriv_q)};
        mul_b = pidta_pkg::abs_data(deriv_q);
      end
      S_MI0: begin
        mul_a = {1'b0, pidta_pkg::abs_data(gain_integ_q)};
        mul_b = isum_mag[DW-1:0];
      end
      S_MI1: begin
        mul_a = {1'b0, pidta_pkg::abs_data(gain_integ_q)};
        mul_b = pidta_pkg::MB_W'(isum_mag[IW-1:DW]);
      end
      default: ;
    endcase
  end

  // Trapezoid step: (e + last) * dt / 2^(FB+1), truncated toward zero.
  logic [pidta_pkg::PROD_W-FB-2:0] step_mag;
  logic signed [IW:0]              step_s;
  logic signed [IW:0]              isum_x, imax_x, imin_x;

  assign step_mag = prod_q[pidta_pkg::PROD_W-1:FB+1];
  assign step_s   = esum_q[DW] ? -$signed((IW + 1)'(step_mag))
                               :  $signed((IW + 1)'(step_mag));
  assign isum_x   = {isum_q[IW-1], isum_q};
  assign imax_x   = {imax_q[IW-1], imax_q};
  assign imin_x   = {imin_q[IW-1], imin_q};

  // Integral term: the high partial product is in prod_q, the low in plo_q.
  logic                                   int_big;
  logic [pidta_pkg::PROD_W-1:0]           int_mag;
  logic signed [pidta_pkg::TERM_W-1:0]    term_i;
  logic signed [pidta_pkg::TERM_W-1:0]    term_d;
  logic signed [pidta_pkg::SUM_W-1:0]     ctl_sum;
  logic signed [pidta_pkg::SUM_W-1:0]     omax_x, omin_x;
  logic [DW-1:0]                          ctl_out;
  pidta_pkg::limit_e                      ctl_lim;

  assign int_big = |prod_q[pidta_pkg::PROD_W-1:2*DW-2-DW];
  assign int_mag = int_big ? pidta_pkg::TERM_LIMIT
                           : ({1'b0, plo_q} +
                              pidta_pkg::PROD_W'({prod_q[DW-3:0], DW'(0)}));
  assign term_i  = pidta_pkg::scale_term(int_mag, gain_integ_q[DW-1] ^ isum_q[IW-1]);
  assign term_d  = pidta_pkg::scale_term(prod_q, gain_deriv_q[DW-1] ^ deriv_q[DW-1]);
  assign ctl_sum = {acc_q[pidta_pkg::TERM_W], acc_q} +
                   {{2{term_i[pidta_pkg::TERM_W-1]}}, term_i};
  assign omax_x  = {{(pidta_pkg::SUM_W - DW){output_max_q[DW-1]}}, output_max_q};
  assign omin_x  = {{(pidta_pkg::SUM_W - DW){output_min_q[DW-1]}}, output_min_q};

  // The maximum is tested first; with reversed limits it wins for sums above it.
  always_comb begin
    if (ctl_sum > omax_x) begin
      ctl_out = output_max_q;
      ctl_lim = pidta_pkg::LIM_MAX;
    end else if (ctl_sum < omin_x) begin
      ctl_out = output_min_q;
      ctl_lim = pidta_pkg::LIM_MIN;
    end else begin
      ctl_out = ctl_sum[DW-1:0];
      ctl_lim = pidta_pkg::LIM_NONE;
    end
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // --------------------------------------------------------------------------
  // Sequencer and control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      started_q  <= 1'b0;
      bnd_ok_q   <= 1'b0;
      last_err_q <= '0;
      isum_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      // A new result refills the register in the cycle the old one leaves.
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (div_req.start) begin
        started_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_err_q <= err_in;
            state_q    <= bnd_ok_q ? S_DDIV : S_BMAX;
          end
        end
        S_BMAX: begin
          if (gi_zero) begin
            bnd_ok_q <= 1'b1;
            state_q  <= S_DDIV;
          end else if (started_q && div_rsp.done) begin
            started_q <= 1'b0;
            state_q   <= S_BMIN;
          end
        end
        S_BMIN: begin
          if (started_q && div_rsp.done) begin
            started_q <= 1'b0;
            bnd_ok_q  <= 1'b1;
            state_q   <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (dt_zero) begin
            state_q <= S_MSTEP;
          end else if (started_q && div_rsp.done) begin
            started_q <= 1'b0;
            state_q   <= S_MSTEP;
          end
        end
        S_MSTEP: state_q <= S_ACC;
        S_ACC:   state_q <= S_CLMP;
        S_CLMP: begin
          if (sum_q > imax_x) begin
            isum_q <= imax_q;
          end else if (sum_q < imin_x) begin
            isum_q <= imin_q;
          end else begin
            isum_q <= sum_q[IW-1:0];
          end
          state_q <= S_MI0;
        end
        S_MI0: state_q <= S_MI1;
        S_MI1: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (bnd_kill) begin
        bnd_ok_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          err_q  <= err_in;
          dt_q   <= dt_in;
          diff_q <= {err_in[DW-1], err_in} - {last_err_q[DW-1], last_err_q};
          esum_q <= {err_in[DW-1], err_in} + {last_err_q[DW-1], last_err_q};
        end
      end
      S_BMAX: begin
        if (gi_zero) begin
          imax_q <= pidta_pkg::IBOUND_DEF;
          imin_q <= -pidta_pkg::IBOUND_DEF;
        end else if (started_q && div_rsp.done) begin
          imax_q <= bmax_new;
        end
      end
      S_BMIN: begin
        if (started_q && div_rsp.done) begin
          if (bmin_new > imax_q) begin
            imin_q <= imax_q;
            imax_q <= bmin_new;
          end else begin
            imin_q <= bmin_new;
          end
        end
      end
      S_DDIV: begin
        if (dt_zero) begin
          deriv_q <= '0;
        end else if (started_q && div_rsp.done) begin
          deriv_q <= q_der[DW-1:0];
        end
      end
      S_ACC:  sum_q    <= isum_x + step_s;
      S_CLMP: term_p_q <= pidta_pkg::scale_term(prod_q, gain_prop_q[DW-1] ^ err_q[DW-1]);
      S_MI0:  acc_q    <= {term_p_q[pidta_pkg::TERM_W-1], term_p_q} +
                          {term_d[pidta_pkg::TERM_W-1], term_d};
      S_MI1:  plo_q    <= prod_q[pidta_pkg::PROD_W-2:0];
      S_OUT: begin
        if (out_free) begin
          m_data_q <= ctl_out;
          m_lim_q  <= ctl_lim;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_lim_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> started_q)
    else $error("divider finished without a pending division");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bnd_ok_q && state_q == S_MSTEP) |-> (imin_q <= imax_q))
    else $error("integral bounds out of order");

  a_integral_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MI0) |-> (isum_q >= imin_q && isum_q <= imax_q))
    else $error("integral outside its bounds after clamping");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && m_valid_q && !m_axis_tready) |=> (state_q == S_OUT))
    else $error("result register overwritten while stalled");

endmodule
